// ===== design/wpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpid_pkg
// Shared types and constants for the windowed peak index detector.
// ----------------------------------------------------------------------------
package wpid_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int MAG_WIDTH    = 17;
   localparam int RADIUS_WIDTH = 6;

   // contents of one window cell
   typedef struct packed {
      logic [MAG_WIDTH-1:0] mag;
      logic                 alive;
   } cell_data_type;

   // per-cell control from the chain
   typedef struct packed {
      logic shift;
      logic in_range;
      logic valid;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

endpackage

// ===== design/wpid_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpid_cell
// One window cell: holds a magnitude and its peak flag, compares against the
// incoming magnitude and hands its contents to the next cell on a shift.
// ----------------------------------------------------------------------------
module wpid_cell (
   input  logic                             clock,
   input  wpid_pkg::cell_ctrl_type          ctrl,
   input  logic [wpid_pkg::MAG_WIDTH-1:0]   new_mag,
   input  wpid_pkg::cell_data_type          shift_in,
   output wpid_pkg::cell_data_type          shift_out,
   output logic                             kill_new
);

   wpid_pkg::cell_data_type data_ff;
   wpid_pkg::cell_data_type data_in;
   logic                    near;

   // compare only while a request is shifting in
   assign near = ctrl.shift & ctrl.valid & ctrl.in_range;

   // older sample beats the newcomer on ties unless both are zero
   assign kill_new = near & (data_ff.mag >= new_mag) & (data_ff.mag != '0);

   always_comb begin
      shift_out.mag   = data_ff.mag;
      shift_out.alive = data_ff.alive & ~(near & (new_mag > data_ff.mag));
   end

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== design/wpid_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpid_chain
// Row of window cells, newest sample at cell 0. Each request shifts the row
// by one and updates the peak flags of everything within the radius.
// ----------------------------------------------------------------------------
module wpid_chain #(
   parameter int DEPTH = 65
) (
   input  logic                            clock,
   input  logic                            shift,
   input  logic [wpid_pkg::MAG_WIDTH-1:0]  new_mag,
   input  logic [$clog2(DEPTH)-1:0]        radius,
   input  logic [$clog2(DEPTH+1)-1:0]      fill,
   output logic [DEPTH-1:0]                alive
);

   wpid_pkg::cell_data_type link [DEPTH+1];
   logic [DEPTH-1:0]        kill_vec;

   // newcomer is a candidate unless an older sample in reach beats it
   always_comb begin
      link[0].mag   = new_mag;
      link[0].alive = ~(|kill_vec);
   end

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      wpid_pkg::cell_ctrl_type ctrl;
      wpid_pkg::cell_data_type held;

      // cell j is j+1 samples before the newcomer
      always_comb begin
         ctrl.shift    = shift;
         ctrl.in_range = (j < int'(radius));
         ctrl.valid    = (j < int'(fill));
      end

      wpid_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_mag   (new_mag),
         .shift_in  (link[j]),
         .shift_out (link[j+1]),
         .kill_new  (kill_vec[j])
      );

      // current flag of the cell; without a shift the output holds the registered contents
      assign held     = link[j+1];
      assign alive[j] = held.alive;
   end

endmodule

// ===== design/windowed_peak_index_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_peak_index_detector_core
// Reports stream indices whose magnitude is the first maximum of its window.
// ----------------------------------------------------------------------------
// A request is taken in ST_IDLE; when a decision is due, it is worked out by
// a walk over the cell flags in ST_EMIT. A non-final request decides the
// index at the radius age once the window holds more than radius samples.
// A final request walks from the oldest age in range down to age 0, one flag
// per cycle while the output can take a peak; no request is taken meanwhile.
// Synchronous reset clears control, counters and radius (0); the window
// cells are not cleared and are read only after being written in a stream.
module windowed_peak_index_detector_core #(
   parameter int MAX_RADIUS  = 32,
   parameter int INDEX_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [wpid_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [INDEX_WIDTH-1:0]               rsp_peak_index,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wpid_pkg::RADIUS_WIDTH-1:0]    csr_data
);

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = $clog2(DEPTH + 1);

   wpid_pkg::state_type state_ff, state_in;

   logic [AW-1:0]          radius_ff, radius_in;
   logic [FW-1:0]          fill_ff, fill_in, fill_next;
   logic [INDEX_WIDTH-1:0] count_ff, count_in;
   logic [INDEX_WIDTH-1:0] cur_ff, cur_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [AW-1:0]          klo_ff, klo_in;
   logic                   out_valid_ff, out_valid_in;
   logic [INDEX_WIDTH-1:0] out_index_ff, out_index_in;
   logic                   out_last_ff, out_last_in;

   logic                          accept;
   logic                          emitting;
   logic [wpid_pkg::SAMPLE_WIDTH-1:0] raw;
   logic [wpid_pkg::MAG_WIDTH-1:0] mag;
   logic [DEPTH-1:0]              alive;
   logic [DEPTH-1:0]              rest_mask;
   logic                          peak_here;
   logic                          any_rest;
   logic                          out_free;
   logic                          advance;
   logic                          load_out;
   logic                          done;
   logic                          decide;
   logic [AW-1:0]                 k_hi;

   assign csr_ready = 1'b1;
   assign accept    = req_valid & req_ready;

   assign raw = req_sample;
   assign mag = raw[wpid_pkg::SAMPLE_WIDTH-1]
              ? (wpid_pkg::MAG_WIDTH'(1 << wpid_pkg::SAMPLE_WIDTH)
                 - {1'b0, raw})
              : {1'b0, raw};

   wpid_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock   (clock),
      .shift   (accept),
      .new_mag (mag),
      .radius  (radius_ff),
      .fill    (fill_ff),
      .alive   (alive)
   );

   // FSM outputs
   always_comb begin
      req_ready = 1'b0;
      emitting  = 1'b0;
      unique case (state_ff)
         wpid_pkg::ST_IDLE: req_ready = 1'b1;
         wpid_pkg::ST_EMIT: emitting  = 1'b1;
         default: ;
      endcase
   end

   // decision range for the request being taken
   assign fill_next = (fill_ff == FW'(DEPTH)) ? fill_ff : fill_ff + 1'b1;
   always_comb begin
      if (fill_next > FW'(radius_ff)) begin
         k_hi = radius_ff;
      end else begin
         k_hi = AW'(fill_next - 1'b1);
      end
   end
   assign decide = (fill_next > FW'(radius_ff)) | req_last;

   // walk over ages k_ff down to klo_ff
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         rest_mask[j] = (j < int'(k_ff)) && (j >= int'(klo_ff));
      end
   end
   assign peak_here = alive[k_ff];
   assign any_rest  = |(alive & rest_mask);
   assign out_free  = ~out_valid_ff | rsp_ready;
   assign advance   = emitting & (~peak_here | out_free);
   assign load_out  = emitting & peak_here & out_free;
   assign done      = (k_ff == klo_ff);

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wpid_pkg::ST_IDLE: begin
            if (accept && decide) begin
               state_in = wpid_pkg::ST_EMIT;
            end
         end
         wpid_pkg::ST_EMIT: begin
            if (advance && done) begin
               state_in = wpid_pkg::ST_IDLE;
            end
         end
         default: state_in = wpid_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      radius_in = radius_ff;
      if (csr_valid && csr_ready) begin
         if (int'(csr_data) > MAX_RADIUS) begin
            radius_in = AW'(MAX_RADIUS);
         end else begin
            radius_in = AW'(csr_data);
         end
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      k_in     = k_ff;
      klo_in   = klo_ff;
      if (accept) begin
         cur_in = count_ff;
         k_in   = k_hi;
         klo_in = req_last ? '0 : radius_ff;
         if (req_last) begin
            fill_in  = '0;
            count_in = '0;
         end else begin
            fill_in  = fill_next;
            count_in = count_ff + 1'b1;
         end
      end else if (advance && !done) begin
         k_in = k_ff - 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_index_in = cur_ff - INDEX_WIDTH'(k_ff);
         out_last_in  = ~any_rest;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpid_pkg::ST_IDLE;
         radius_ff    <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      k_ff         <= k_in;
      klo_ff       <= klo_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_peak_index  = out_index_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
